>>> sv/rmedf_pkg.sv
// Shared types, codes and constants of the periodic task scheduler.
package rmedf_pkg;

    localparam int TASK_SLOTS_DEF = 16;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REASON_IDLE    = 3'd0,
        REASON_PREEMPT = 3'd1,
        REASON_MISSED  = 3'd2,
        REASON_DONE    = 3'd3,
        REASON_ABORT   = 3'd4
    } end_reason_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SEL,
        S_RUN,
        S_FSCAN,
        S_DRAIN,
        S_WAIT
    } state_t;

    localparam logic [0:0] CFG_ALGORITHM  = 1'b0;
    localparam logic [0:0] CFG_TASK_COUNT = 1'b1;
    localparam logic [4:0] IDLE_TASK      = 5'h1F;
    localparam logic       KIND_BLOCK     = 1'b0;
    localparam logic       KIND_REPORT    = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [4:0]  block_task;
        logic [31:0] block_units;
        logic [2:0]  end_reason;
        logic [31:0] lost_count;
        logic [31:0] completed_count;
        logic [31:0] killed_count;
    } res_t;

endpackage

>>> sv/rmedf_obuf.sv
// Two-entry result buffer that collects the results of one command and drains them.
module rmedf_obuf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_i,
    input  rmedf_pkg::res_t    item_i,
    input  logic               start_i,
    output logic               busy_o,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [135:0]       m_tdata,  // block_task, block_units, end_reason, lost, completed, killed
    output logic [0:0]         m_tuser,  // kind
    output logic               m_tlast
);
    rmedf_pkg::res_t ent_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       drain_reg;
    rmedf_pkg::res_t cur;

    assign cur      = ent_reg[rd_reg];
    assign busy_o   = drain_reg;
    assign m_tvalid = drain_reg && (cnt_reg != 2'd0);
    assign m_tlast  = ({1'b0, rd_reg} + 2'd1) == cnt_reg;
    assign m_tuser  = cur.kind;
    assign m_tdata  = {cur.killed_count, cur.completed_count, cur.lost_count,
                       cur.end_reason, cur.block_units, cur.block_task};

    always_ff @(posedge aclk) begin
        if (push_i && !cnt_reg[1]) begin
            ent_reg[cnt_reg[0]] <= item_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= 2'd0;
            rd_reg    <= 1'b0;
            drain_reg <= 1'b0;
        end else if (start_i) begin
            drain_reg <= (cnt_reg != 2'd0);
        end else if (m_tvalid && m_tready) begin
            if (m_tlast) begin
                cnt_reg   <= 2'd0;
                rd_reg    <= 1'b0;
                drain_reg <= 1'b0;
            end else begin
                rd_reg <= 1'b1;
            end
        end else if (push_i && !cnt_reg[1]) begin
            cnt_reg <= cnt_reg + 2'd1;
        end
    end
endmodule

>>> sv/rm_edf_tick_scheduler.sv
// Top level of the preemptive rate monotonic / earliest deadline first tick scheduler.
//
// Commands arrive as transfers on the s_ channel: s_tuser carries the command,
// s_tdata the task slot and, for a load, the period, burst and deadline.
// Results leave on the m_ channel: m_tuser tells a timeline block from a
// counter report, m_tlast marks the final result of a command.
// Configuration is written through cfg_we, cfg_addr and cfg_wdata; the user
// must write it only while idle, which the block itself does not enforce.
// A tick walks the participating task slots one per cycle through a single
// compare and add unit, then runs the selected task for one time unit; a
// finish walks the same slots to count and clear the jobs still active.
// The block accepts one command at a time and s_tready stays low until all
// results of the current command are taken. When the receiver stalls the
// result holds on the m_ port and the block waits.
// Reset clears the time, job state, counters and the open block; task
// parameters are undefined until loaded.
module rm_edf_tick_scheduler #(
    parameter int TASK_SLOTS = rmedf_pkg::TASK_SLOTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,  // task_index, period, burst, deadline
    input  logic [1:0]   s_tuser,  // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,  // block_task, block_units, end_reason, lost, completed, killed
    output logic [0:0]   m_tuser,  // kind
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_addr,
    input  logic [4:0]   cfg_wdata
);
    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);

    rmedf_pkg::state_t state_reg, state_next;

    logic        alg_reg;
    logic [4:0]  tcnt_reg;

    logic [15:0] period_mem [TASK_SLOTS];
    logic [15:0] burst_mem  [TASK_SLOTS];
    logic [15:0] reldl_mem  [TASK_SLOTS];
    logic        act_reg    [TASK_SLOTS];
    logic [15:0] rem_reg    [TASK_SLOTS];
    logic [31:0] absdl_reg  [TASK_SLOTS];
    logic [15:0] cd_reg     [TASK_SLOTS];
    logic [31:0] lost_reg   [TASK_SLOTS];
    logic [31:0] comp_reg   [TASK_SLOTS];
    logic [31:0] kill_reg   [TASK_SLOTS];

    logic [31:0] time_reg, time_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          bvalid_reg, bvalid_next;
    logic [SW-1:0] bidx_reg, bidx_next;
    logic [31:0]   bkey_reg, bkey_next;
    logic          ovalid_reg, ovalid_next;
    logic          oidle_reg, oidle_next;
    logic [SW-1:0] oidx_reg, oidx_next;
    logic [31:0]   len_reg, len_next;

    logic [1:0]  in_cmd;
    logic [3:0]  in_ti;
    logic [15:0] in_period, in_burst, in_deadline;
    logic        in_ok, accept;
    logic [SW-1:0] in_slot, ii;
    logic [7:0]  n8;
    logic [CW-1:0] n;
    logic        last_slot;

    logic        sl_lost, sl_act, sl_cand;
    logic [15:0] sl_rem, sl_cd;
    logic [31:0] sl_dl, sl_key, len_base;
    logic        own_is_ii, same;

    logic            push;
    rmedf_pkg::res_t push_item;
    logic            drain_start, ob_busy;

    assign in_cmd      = s_tuser;
    assign in_ti       = s_tdata[3:0];
    assign in_period   = s_tdata[19:4];
    assign in_burst    = s_tdata[35:20];
    assign in_deadline = s_tdata[51:36];
    assign in_ok       = 32'(in_ti) < 32'(TASK_SLOTS);
    assign in_slot     = SW'(in_ti);
    assign s_tready    = (state_reg == rmedf_pkg::S_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign n8          = ({3'b0, tcnt_reg} > 8'(TASK_SLOTS)) ? 8'(TASK_SLOTS)
                                                             : {3'b0, tcnt_reg};
    assign n           = CW'(n8);
    assign ii          = idx_reg[SW-1:0];
    assign last_slot   = CW'(idx_reg + CW'(1)) == n;

    always_comb begin
        sl_lost = act_reg[ii] && (absdl_reg[ii] <= time_reg);
        if (cd_reg[ii] == 16'd0) begin
            sl_act = 1'b1;
            sl_rem = burst_mem[ii];
            sl_dl  = time_reg + {16'd0, reldl_mem[ii]};
            sl_cd  = (period_mem[ii] != 16'd0) ? period_mem[ii] - 16'd1 : 16'd0;
        end else begin
            sl_act = act_reg[ii] && !sl_lost;
            sl_rem = rem_reg[ii];
            sl_dl  = absdl_reg[ii];
            sl_cd  = cd_reg[ii] - 16'd1;
        end
        sl_cand   = sl_act && (sl_rem != 16'd0);
        sl_key    = alg_reg ? sl_dl : {16'd0, period_mem[ii]};
        own_is_ii = ovalid_reg && !oidle_reg && (oidx_reg == ii);
        same      = bvalid_reg ? (ovalid_reg && !oidle_reg && (oidx_reg == bidx_reg))
                               : (ovalid_reg && oidle_reg);
        len_base  = same ? len_reg : 32'd0;
    end

    always_comb begin
        state_next  = state_reg;
        time_next   = time_reg;
        idx_next    = idx_reg;
        bvalid_next = bvalid_reg;
        bidx_next   = bidx_reg;
        bkey_next   = bkey_reg;
        ovalid_next = ovalid_reg;
        oidle_next  = oidle_reg;
        oidx_next   = oidx_reg;
        len_next    = len_reg;
        push        = 1'b0;
        push_item   = '0;
        drain_start = 1'b0;
        case (state_reg)
            rmedf_pkg::S_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        rmedf_pkg::CMD_TICK: begin
                            idx_next    = '0;
                            bvalid_next = 1'b0;
                            state_next  = (n == '0) ? rmedf_pkg::S_SEL : rmedf_pkg::S_SCAN;
                        end
                        rmedf_pkg::CMD_FINISH: begin
                            push                 = ovalid_reg && (len_reg != 32'd0);
                            push_item.kind       = rmedf_pkg::KIND_BLOCK;
                            push_item.block_task = oidle_reg ? rmedf_pkg::IDLE_TASK
                                                             : 5'(oidx_reg);
                            push_item.block_units = len_reg;
                            push_item.end_reason = oidle_reg ? rmedf_pkg::REASON_IDLE
                                                             : rmedf_pkg::REASON_ABORT;
                            ovalid_next = 1'b0;
                            len_next    = 32'd0;
                            idx_next    = '0;
                            state_next  = (n == '0) ? rmedf_pkg::S_DRAIN
                                                    : rmedf_pkg::S_FSCAN;
                        end
                        rmedf_pkg::CMD_READ: begin
                            push           = 1'b1;
                            push_item.kind = rmedf_pkg::KIND_REPORT;
                            if (in_ok) begin
                                push_item.lost_count      = lost_reg[in_slot];
                                push_item.completed_count = comp_reg[in_slot];
                                push_item.killed_count    = kill_reg[in_slot];
                            end
                            state_next = rmedf_pkg::S_DRAIN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rmedf_pkg::S_SCAN: begin
                if (sl_lost && own_is_ii) begin
                    push                  = (len_reg != 32'd0);
                    push_item.kind        = rmedf_pkg::KIND_BLOCK;
                    push_item.block_task  = 5'(ii);
                    push_item.block_units = len_reg;
                    push_item.end_reason  = rmedf_pkg::REASON_MISSED;
                    ovalid_next = 1'b0;
                    len_next    = 32'd0;
                end
                if (sl_cand && (!bvalid_reg || (sl_key < bkey_reg))) begin
                    bvalid_next = 1'b1;
                    bidx_next   = ii;
                    bkey_next   = sl_key;
                end
                idx_next   = CW'(idx_reg + CW'(1));
                state_next = last_slot ? rmedf_pkg::S_SEL : rmedf_pkg::S_SCAN;
            end
            rmedf_pkg::S_SEL: begin
                if (!same) begin
                    push                  = ovalid_reg && (len_reg != 32'd0);
                    push_item.kind        = rmedf_pkg::KIND_BLOCK;
                    push_item.block_task  = oidle_reg ? rmedf_pkg::IDLE_TASK : 5'(oidx_reg);
                    push_item.block_units = len_reg;
                    push_item.end_reason  = oidle_reg ? rmedf_pkg::REASON_IDLE
                                                      : rmedf_pkg::REASON_PREEMPT;
                    ovalid_next = 1'b1;
                    oidle_next  = !bvalid_reg;
                    oidx_next   = bidx_reg;
                end
                len_next   = (len_base == 32'hFFFF_FFFF) ? len_base : len_base + 32'd1;
                state_next = rmedf_pkg::S_RUN;
            end
            rmedf_pkg::S_RUN: begin
                if (bvalid_reg && (rem_reg[bidx_reg] == 16'd1)) begin
                    push                  = 1'b1;
                    push_item.kind        = rmedf_pkg::KIND_BLOCK;
                    push_item.block_task  = 5'(bidx_reg);
                    push_item.block_units = len_reg;
                    push_item.end_reason  = rmedf_pkg::REASON_DONE;
                    ovalid_next = 1'b0;
                    len_next    = 32'd0;
                end
                time_next  = time_reg + 32'd1;
                state_next = rmedf_pkg::S_DRAIN;
            end
            rmedf_pkg::S_FSCAN: begin
                idx_next   = CW'(idx_reg + CW'(1));
                state_next = last_slot ? rmedf_pkg::S_DRAIN : rmedf_pkg::S_FSCAN;
            end
            rmedf_pkg::S_DRAIN: begin
                drain_start = 1'b1;
                state_next  = rmedf_pkg::S_WAIT;
            end
            rmedf_pkg::S_WAIT: begin
                if (!ob_busy) begin
                    state_next = rmedf_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rmedf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= rmedf_pkg::S_IDLE;
            alg_reg    <= 1'b0;
            tcnt_reg   <= 5'd1;
            time_reg   <= 32'd0;
            idx_reg    <= '0;
            bvalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            oidle_reg  <= 1'b0;
            len_reg    <= 32'd0;
        end else begin
            state_reg  <= state_next;
            time_reg   <= time_next;
            idx_reg    <= idx_next;
            bvalid_reg <= bvalid_next;
            ovalid_reg <= ovalid_next;
            oidle_reg  <= oidle_next;
            len_reg    <= len_next;
            if (cfg_we) begin
                case (cfg_addr)
                    rmedf_pkg::CFG_ALGORITHM:  alg_reg  <= cfg_wdata[0];
                    rmedf_pkg::CFG_TASK_COUNT: tcnt_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        bidx_reg <= bidx_next;
        bkey_reg <= bkey_next;
        oidx_reg <= oidx_next;
        if (accept && (in_cmd == rmedf_pkg::CMD_LOAD) && in_ok) begin
            period_mem[in_slot] <= in_period;
            burst_mem[in_slot]  <= in_burst;
            reldl_mem[in_slot]  <= in_deadline;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < TASK_SLOTS; k++) begin
                act_reg[k]   <= 1'b0;
                rem_reg[k]   <= 16'd0;
                absdl_reg[k] <= 32'd0;
                cd_reg[k]    <= 16'd0;
                lost_reg[k]  <= 32'd0;
                comp_reg[k]  <= 32'd0;
                kill_reg[k]  <= 32'd0;
            end
        end else begin
            case (state_reg)
                rmedf_pkg::S_SCAN: begin
                    act_reg[ii]   <= sl_act;
                    rem_reg[ii]   <= sl_rem;
                    absdl_reg[ii] <= sl_dl;
                    cd_reg[ii]    <= sl_cd;
                    if (sl_lost) begin
                        lost_reg[ii] <= lost_reg[ii] + 32'd1;
                    end
                end
                rmedf_pkg::S_RUN: begin
                    if (bvalid_reg) begin
                        rem_reg[bidx_reg] <= rem_reg[bidx_reg] - 16'd1;
                        if (rem_reg[bidx_reg] == 16'd1) begin
                            act_reg[bidx_reg]  <= 1'b0;
                            comp_reg[bidx_reg] <= comp_reg[bidx_reg] + 32'd1;
                        end
                    end
                end
                rmedf_pkg::S_FSCAN: begin
                    if (act_reg[ii]) begin
                        kill_reg[ii] <= kill_reg[ii] + 32'd1;
                        act_reg[ii]  <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    rmedf_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_i   (push),
        .item_i   (push_item),
        .start_i  (drain_start),
        .busy_o   (ob_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_out_only_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (state_reg == rmedf_pkg::S_WAIT))
        else $error("result offered outside the drain phase");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input taken while results are pending");

    a_run_after_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rmedf_pkg::S_RUN) |-> ($past(state_reg) == rmedf_pkg::S_SEL))
        else $error("run step without selection");
endmodule
